/* rtl/polyphase_fir_decimator_assert.svh */
// Assertion macros for the polyphase FIR decimator
`ifndef POLYPHASE_FIR_DECIMATOR_ASSERT_SVH
`define POLYPHASE_FIR_DECIMATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define PFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pfd: assertion failed");
// Check that an antecedent implies a consequent in the same cycle
`define PFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfd: implication failed");
`else
`define PFD_ASSERT(lbl, prop)
`define PFD_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

/* rtl/pfd_pkg.sv */
// Package with sizes, defaults and codes of the polyphase FIR decimator
package pfd_pkg;

  localparam int unsigned MAX_TAPS_DEF    = 64;
  localparam int unsigned MAX_FACTOR_DEF  = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COEF_BITS_DEF   = 16;

  // Register field widths and reset values
  localparam int unsigned FACTOR_REG_W = 4;
  localparam int unsigned TAPS_REG_W   = 7;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = FACTOR_REG_W'(2);
  localparam logic [TAPS_REG_W-1:0]   TAPS_RESET   = TAPS_REG_W'(64);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = CFG_IDX_W'(1);

  // Item modes
  localparam int unsigned MODE_W = 2;
  localparam int unsigned COEF_IDX_W = 6;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_COEF   = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_CLEAR  = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_NONE   = MODE_W'(3);

endpackage

/* rtl/polyphase_fir_decimator.sv */
// Polyphase FIR decimator with one shared multiply-accumulate unit
//
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   mode_i, sample_in_i, coef_index_i, coef_value_i
// out       source     out_valid_o / out_stall_i sample_out_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample item serving phase p issues ceil((N - p) / M) products (none when no tap falls in
// its phase), one product per cycle through the single multiplier, with accept, memory read,
// product and drain steps around them before the next accept. The sample that serves phase
// 0 then loads the output register, and holds there while a result still
// waits unaccepted. Coefficient, clear and unused items leave the sequencer idle. At 64 taps
// and factor 8 a sample issues 8 products. Items are held off while a register write is offered.
// Reset clears the sample history and coefficient store at once through per-entry valid bits;
// no clearing pass is needed.
module polyphase_fir_decimator #(
  parameter int unsigned MAX_TAPS    = pfd_pkg::MAX_TAPS_DEF,
  parameter int unsigned MAX_FACTOR  = pfd_pkg::MAX_FACTOR_DEF,
  parameter int unsigned SAMPLE_BITS = pfd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEF_BITS   = pfd_pkg::COEF_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pfd_pkg::MODE_W-1:0]           mode_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in_i,
  input  logic [pfd_pkg::COEF_IDX_W-1:0]       coef_index_i,
  input  logic signed [COEF_BITS-1:0]          coef_value_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        sample_out_o,
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pfd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  `include "polyphase_fir_decimator_assert.svh"

  localparam int unsigned PTR_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned FACT_W = $clog2(MAX_FACTOR + 1);
  localparam int unsigned TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int unsigned K_W    = $clog2(MAX_TAPS + MAX_FACTOR + 1);
  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int unsigned RND_W  = ACC_W + 1;
  localparam int unsigned FB     = COEF_BITS - 1;
  localparam logic signed [RND_W-1:0] SAT_HI =
    RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_TAPS - 1);

  // Sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration registers
  logic [pfd_pkg::FACTOR_REG_W-1:0] fact_reg_q;
  logic [pfd_pkg::TAPS_REG_W-1:0]   taps_reg_q;
  logic [FACT_W-1:0] fact_eff;
  logic [TAP_W-1:0]  taps_eff;

  // Stores: history as a circular buffer, coefficients by tap number
  logic [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]    hist_vld_q;
  logic [MAX_TAPS-1:0]    coef_vld_q;
  logic [PTR_W-1:0]       wp_q, wp_next;

  // Sequencer and datapath registers
  logic [FACT_W-1:0] phase_q, phase_d;
  logic [K_W-1:0]    k_q, k_d, j_q, j_d;
  logic              iss;
  logic [PTR_W-1:0]  haddr;
  logic signed [K_W:0] hdiff;

  logic                          rd_v_q, prod_v_q;
  logic signed [SAMPLE_BITS-1:0] hist_rd_q;
  logic                          hist_rd_vld_q;
  logic signed [COEF_BITS-1:0]   coef_rd_q;
  logic                          coef_rd_vld_q;
  logic signed [SAMPLE_BITS-1:0] op_a;
  logic signed [COEF_BITS-1:0]   op_b;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [RND_W-1:0]       rnd, shifted;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  logic in_acc, cfg_acc, out_free, restart;
  logic is_sample, is_coef, is_clear;
  logic [FACT_W-1:0] phase_start;

  // Clamp the registers to their usable ranges
  assign fact_eff = (fact_reg_q == '0) ? FACT_W'(1) :
                    (32'(fact_reg_q) > MAX_FACTOR) ? FACT_W'(MAX_FACTOR) :
                    FACT_W'(fact_reg_q);
  assign taps_eff = (32'(taps_reg_q) > MAX_TAPS) ? TAP_W'(MAX_TAPS) : TAP_W'(taps_reg_q);

  // Hold items off while a register write is offered, so the two never meet
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign is_sample = in_acc && (mode_i == pfd_pkg::MODE_SAMPLE);
  assign is_coef   = in_acc && (mode_i == pfd_pkg::MODE_COEF);
  assign is_clear  = in_acc && (mode_i == pfd_pkg::MODE_CLEAR);

  // A write to the factor or taps register, or a coefficient load, restarts the filter
  assign restart = is_coef ||
                   (cfg_acc && ((cfg_index_i == pfd_pkg::CFG_FACTOR) ||
                                (cfg_index_i == pfd_pkg::CFG_TAPS)));

  // A phase of zero stands for a full count of M; serve the phase one below it
  assign phase_start = ((phase_q == '0) || (phase_q > fact_eff)) ? fact_eff - FACT_W'(1)
                                                                  : phase_q - FACT_W'(1);

  assign wp_next = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);

  // Issue one tap per cycle while the tap number stays below N
  assign iss = (state_q == S_MAC) && (k_q < K_W'(taps_eff));

  // History entry j samples back sits j slots behind the write pointer
  always_comb begin
    hdiff = $signed({{(K_W + 1 - PTR_W){1'b0}}, wp_q}) - $signed({1'b0, j_q});
    if (hdiff < 0) begin
      hdiff = hdiff + (K_W + 1)'(MAX_TAPS);
    end
    haddr = hdiff[PTR_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    k_d     = k_q;
    j_d     = j_q;
    unique case (state_q)
      S_IDLE: begin
        if (restart) begin
          phase_d = '0;
        end else if (is_sample) begin
          phase_d = phase_start;
          k_d     = K_W'(phase_start);
          j_d     = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        if (iss) begin
          k_d = k_q + K_W'(fact_eff);
          j_d = j_q + K_W'(fact_eff);
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !prod_v_q) begin
          state_d = (phase_q == '0) ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Round half up, then saturate
  always_comb begin
    rnd     = $signed({acc_q[ACC_W-1], acc_q}) + (RND_W'(1) <<< (FB - 1));
    shifted = rnd >>> FB;
    if (shifted > SAT_HI) begin
      sat = SAMPLE_BITS'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      sat = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat = shifted[SAMPLE_BITS-1:0];
    end
  end

  // Invalid entries read as zero
  assign op_a = hist_rd_vld_q ? hist_rd_q : '0;
  assign op_b = coef_rd_vld_q ? coef_rd_q : '0;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fact_reg_q  <= pfd_pkg::FACTOR_RESET;
      taps_reg_q  <= pfd_pkg::TAPS_RESET;
      phase_q     <= '0;
      k_q         <= '0;
      j_q         <= '0;
      wp_q        <= '0;
      hist_vld_q  <= '0;
      coef_vld_q  <= '0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      k_q      <= k_d;
      j_q      <= j_d;
      rd_v_q   <= iss;
      prod_v_q <= rd_v_q;

      if (cfg_acc && (cfg_index_i == pfd_pkg::CFG_FACTOR)) begin
        fact_reg_q <= cfg_data_i[pfd_pkg::FACTOR_REG_W-1:0];
      end
      if (cfg_acc && (cfg_index_i == pfd_pkg::CFG_TAPS)) begin
        taps_reg_q <= cfg_data_i[pfd_pkg::TAPS_REG_W-1:0];
      end

      // Drop the history on restart or clear; mark a fresh sample valid
      if (restart || is_clear) begin
        hist_vld_q <= '0;
      end else if (is_sample) begin
        hist_vld_q[wp_next] <= 1'b1;
        wp_q <= wp_next;
      end
      if (is_coef && (32'(coef_index_i) < MAX_TAPS)) begin
        coef_vld_q[PTR_W'(coef_index_i)] <= 1'b1;
      end

      // Accumulate one product per cycle; clear on restart and after emitting
      if (restart) begin
        acc_q <= '0;
      end else if (prod_v_q) begin
        acc_q <= acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end else if ((state_q == S_EMIT) && out_free) begin
        acc_q <= '0;
      end

      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stores, read data and payload registers
  always_ff @(posedge clk_i) begin
    if (is_sample) begin
      hist_mem[wp_next] <= sample_in_i;
    end
    if (is_coef && (32'(coef_index_i) < MAX_TAPS)) begin
      coef_mem[PTR_W'(coef_index_i)] <= coef_value_i;
    end
    if (iss) begin
      hist_rd_q     <= hist_mem[haddr];
      hist_rd_vld_q <= hist_vld_q[haddr];
      coef_rd_q     <= coef_mem[k_q[PTR_W-1:0]];
      coef_rd_vld_q <= coef_vld_q[k_q[PTR_W-1:0]];
    end
    if (rd_v_q) begin
      prod_q <= op_a * op_b;
    end
    if ((state_q == S_EMIT) && out_free) begin
      out_q <= sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  `PFD_ASSERT(a_idle_pipe_empty, (state_q != S_IDLE) || (!rd_v_q && !prod_v_q))
  `PFD_ASSERT_IMP(a_emit_at_phase_zero, state_q == S_EMIT, phase_q == '0)
  `PFD_ASSERT_IMP(a_out_from_emit, $rose(out_valid_q), $past(state_q) == S_EMIT)
  `PFD_ASSERT_IMP(a_read_from_mac, rd_v_q, $past(state_q) == S_MAC)

endmodule
